FILE: src/jtr_pkg.sv
// ----------------------------------------------------------------------------
// jtr_pkg
// Shared types and constants of the transport reassembler.
// ----------------------------------------------------------------------------
package jtr_pkg;

    localparam logic [23:0] PGN_CM = 24'h00EC00;
    localparam logic [23:0] PGN_DT = 24'h00EB00;
    localparam logic [7:0]  CTL_BAM = 8'd32;
    localparam logic [7:0]  CTL_RTS = 8'd16;
    localparam logic [7:0]  CTL_ABORT = 8'd255;
    localparam logic [7:0]  PF_PDU2 = 8'd240;
    localparam logic [7:0]  PF_DIAG_A = 8'hDA;
    localparam logic [7:0]  PF_DIAG_B = 8'hDB;

    localparam logic [1:0] ST_IGNORED  = 2'd0;
    localparam logic [1:0] ST_CONSUMED = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [28:0] frame_id;
        logic        extended;
        logic        remote_request;
        logic        error_frame;
        logic        received;
        logic [15:0] channel;
        logic [3:0]  length;
        logic [63:0] payload;
    } frame_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] group_number;
        logic [2:0]  priority_res;
        logic        reserved_bit;
        logic        data_page;
        logic [7:0]  pdu_format;
        logic [7:0]  pdu_specific;
        logic [7:0]  source_addr;
        logic [63:0] out_bytes;
        logic [3:0]  out_count;
        logic        from_transport;
    } result_t;

    // one session slot
    typedef struct packed {
        logic [32:0] key;
        logic [23:0] group;
        logic [15:0] size;
        logic [7:0]  packets;
        logic [7:0]  seen;
        logic [15:0] bytes;
        logic [28:0] header;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // fill result header fields
    function automatic result_t put_header(input result_t r, input logic [23:0] grp,
                                           input logic [28:0] hdr);
        result_t o;
        o = r;
        o.group_number = grp;
        o.priority_res = hdr[28:26];
        o.reserved_bit = hdr[25];
        o.data_page    = hdr[24];
        o.pdu_format   = hdr[23:16];
        o.pdu_specific = hdr[15:8];
        o.source_addr  = hdr[7:0];
        return o;
    endfunction

endpackage

FILE: src/jtr_ram.sv
// ----------------------------------------------------------------------------
// jtr_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module jtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/j1939_transport_reassembler_unit.sv
// ----------------------------------------------------------------------------
// j1939_transport_reassembler_unit
// J1939 transport session reassembler over a small slot table.
// ----------------------------------------------------------------------------
// One CAN frame is taken per item and one result item is produced. The
// session table sits in a RAM and is scanned one slot per cycle by a single
// key comparator. A transport frame passes from acceptance through decode,
// a scan of every slot, a read of the hit slot, the update and the
// hand-over. Other frames, and short connection-management frames, go from
// decode straight to the hand-over. The input stalls while a frame is worked
// on. A finished result sits in the output register, so the next frame can
// start while it waits; the sequencer holds at hand-over only while the
// previous result is still stalled. Slot valid bits live in flip-flops and
// are cleared by reset.
module j1939_transport_reassembler_unit #(
    parameter int SESSIONS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  jtr_pkg::frame_t   in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output jtr_pkg::result_t  out_data
);
    import jtr_pkg::*;

    localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int RD = (SESSIONS > 1) ? SESSIONS : 2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_SCAN = 6'b000100,
        S_WAIT = 6'b001000,
        S_EXEC = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    frame_t frm_reg;
    logic [SESSIONS-1:0] valid_reg, valid_next;
    logic [IW:0]  idx_reg, idx_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic found_reg, found_next;
    logic is_cm_reg, is_cm_next;
    result_t res_reg, res_next;
    result_t out_data_reg, out_data_next;
    logic out_valid_reg, out_valid_next;

    logic we;
    logic [IW-1:0] waddr, raddr;
    slot_t wdata, rdata;

    // frame decode
    logic [28:0] id;
    logic [3:0]  len;
    logic [7:0]  pf, ps, sa;
    logic [23:0] pgn;
    logic [32:0] key;
    logic [IW-1:0] scan_idx;

    assign id  = frm_reg.frame_id;
    assign len = (frm_reg.length > 4'd8) ? 4'd8 : frm_reg.length;
    assign pf  = id[23:16];
    assign ps  = id[15:8];
    assign sa  = id[7:0];
    assign pgn = {6'd0, id[25], id[24], pf, (pf >= PF_PDU2) ? ps : 8'd0};
    assign key = {frm_reg.channel, ~frm_reg.received, sa, ps};
    assign scan_idx = idx_reg[IW-1:0];

    jtr_ram #(.WIDTH(SLOT_W), .DEPTH(RD)) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // lowest free slot
    logic          free_any;
    logic [IW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SESSIONS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // sequencer and per-item work
    logic [7:0]  seq_next;
    logic [15:0] room;
    logic [3:0]  avail, take;
    logic [63:0] mask;
    slot_t s_upd;
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        is_cm_next     = is_cm_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        we    = 1'b0;
        waddr = hit_reg;
        wdata = rdata;
        raddr = scan_idx;
        seq_next = rdata.seen + 8'd1;
        room  = rdata.size - rdata.bytes;
        avail = (len == 4'd0) ? 4'd0 : len - 4'd1;
        take  = (rdata.bytes >= rdata.size) ? 4'd0 :
                ((room < {12'd0, avail}) ? room[3:0] : avail);
        mask  = '0;
        s_upd = rdata;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_next   = '0;
                idx_next   = '0;
                found_next = 1'b0;
                is_cm_next = (pgn == PGN_CM);
                if (frm_reg.error_frame || frm_reg.remote_request || !frm_reg.extended)
                begin
                    state_next = S_OUT;
                end
                else if (pgn == PGN_CM || pgn == PGN_DT)
                begin
                    if (pgn == PGN_CM && len < 4'd8)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if (pf != PF_DIAG_A && pf != PF_DIAG_B)
                    begin
                        for (int b = 0; b < 8; b++)
                        begin
                            mask[b*8 +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
                        end
                        res_next = put_header('0, pgn, id);
                        res_next.status    = ST_DONE;
                        res_next.out_bytes = frm_reg.payload & mask;
                        res_next.out_count = len;
                    end
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                // one slot key compare per cycle; read data is registered, so the compare uses the previous index
                if (idx_reg != '0 && !found_reg)
                begin
                    if (valid_reg[IW'(idx_reg - 1'b1)] && rdata.key == key)
                    begin
                        found_next = 1'b1;
                        hit_next   = IW'(idx_reg - 1'b1);
                    end
                end
                if (idx_reg == (IW+1)'(SESSIONS))
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                raddr = hit_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                if (is_cm_reg)
                begin
                    if (frm_reg.payload[7:0] == CTL_BAM || frm_reg.payload[7:0] == CTL_RTS)
                    begin
                        if (!found_reg && !free_any)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            waddr = found_reg ? hit_reg : free_idx;
                            we    = 1'b1;
                            wdata.key     = key;
                            wdata.size    = frm_reg.payload[23:8];
                            wdata.packets = frm_reg.payload[31:24];
                            wdata.group   = frm_reg.payload[63:40];
                            wdata.seen    = '0;
                            wdata.bytes   = '0;
                            wdata.header  = id;
                            valid_next[waddr] = 1'b1;
                            res_next = put_header('0, frm_reg.payload[63:40], id);
                            res_next.status = ST_CONSUMED;
                            res_next.from_transport = 1'b1;
                        end
                    end
                    else if (found_reg && frm_reg.payload[7:0] == CTL_ABORT)
                    begin
                        valid_next[hit_reg] = 1'b0;
                    end
                    else if (found_reg)
                    begin
                        res_next = put_header('0, rdata.group, rdata.header);
                        res_next.status = ST_CONSUMED;
                        res_next.from_transport = 1'b1;
                    end
                end
                else if (found_reg)
                begin
                    if (frm_reg.payload[7:0] != seq_next)
                    begin
                        valid_next[hit_reg] = 1'b0;
                    end
                    else
                    begin
                        s_upd.seen  = seq_next;
                        s_upd.bytes = rdata.bytes + {12'd0, take};
                        we    = 1'b1;
                        wdata = s_upd;
                        for (int b = 0; b < 8; b++)
                        begin
                            mask[b*8 +: 8] = (4'(b) < take) ? 8'hFF : 8'h00;
                        end
                        res_next = put_header('0, rdata.group, rdata.header);
                        res_next.out_bytes = {8'd0, frm_reg.payload[63:8]} & mask;
                        res_next.out_count = take;
                        res_next.from_transport = 1'b1;
                        if (s_upd.seen >= rdata.packets || s_upd.bytes >= rdata.size)
                        begin
                            valid_next[hit_reg] = 1'b0;
                            res_next.status = ST_DONE;
                        end
                        else
                        begin
                            res_next.status = ST_CONSUMED;
                        end
                    end
                end
            end
            S_OUT:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            frm_reg <= in_data;
        end
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
        is_cm_reg    <= is_cm_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input open while busy");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_valid_reg && out_stall |=>
        state_reg == S_OUT && out_valid_reg)
        else $error("result overwritten");
endmodule
